### rtl/utf7e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf7e_pkg
// Shared types, character codes and base64 helpers for the UTF-7 encoder.
// ============================================================================
package utf7e_pkg;

    // Depth of the job queue between front and back end
    localparam int unsigned JOBQ_DEPTH = 2;
    // Most bytes a single transaction can produce
    localparam int unsigned MAX_BYTES  = 6;

    // Encoder mode codes (base64 with 0, 2 or 4 bits held)
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_B64_0 = 2'd1;
    localparam logic [1:0] MODE_B64_2 = 2'd2;
    localparam logic [1:0] MODE_B64_4 = 2'd3;

    // Function codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // Character codes
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_AMP   = 7'h26;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_SLASH = 7'h2F;

    // First code point outside the Unicode range
    localparam logic [30:0] CP_LIMIT = 31'h0011_0000;

    // One decoded transaction: the bytes it produces, in order
    typedef struct packed {
        logic [MAX_BYTES-1:0][6:0] bytes;
        logic [2:0]                cnt;     // results to deliver, 1..6
        logic                      vld;     // bytes carry data
        logic                      status;  // illegal code point skipped
    } t_job;

    // Base64 digit for a 6-bit value
    function automatic logic [6:0] b64_digit(input logic [5:0] v, input logic imap);
        logic [6:0] ch;
        if (v < 6'd26) begin
            ch = {1'b0, v} + 7'h41;
        end else if (v < 6'd52) begin
            ch = {1'b0, 6'(v - 6'd26)} + 7'h61;
        end else if (v < 6'd62) begin
            ch = {1'b0, 6'(v - 6'd52)} + 7'h30;
        end else if (v == 6'd62) begin
            ch = CH_PLUS;
        end else begin
            ch = imap ? CH_COMMA : CH_SLASH;
        end
        return ch;
    endfunction

    // Characters sent as themselves in ASCII mode
    function automatic logic is_direct(input logic [30:0] c, input logic imap);
        logic       lo;
        logic [6:0] c7;
        logic       res;
        lo = (c[30:7] == 24'd0);
        c7 = c[6:0];
        if (imap) begin
            res = lo && (c7 != CH_AMP) && (c7 inside {[7'h20:7'h7E]});
        end else begin
            res = lo && (c7 inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h30:7'h39],
                                    7'h27, 7'h28, 7'h29, [7'h2C:7'h2F], 7'h3A,
                                    7'h3F, 7'h20, 7'h09, 7'h0A, 7'h0D});
        end
        return res;
    endfunction

    // Characters that would be read as base64 unless '-' closes the run
    function automatic logic explicit_close(input logic [30:0] c);
        logic       lo;
        logic [6:0] c7;
        lo = (c[30:7] == 24'd0);
        c7 = c[6:0];
        return lo && (c7 inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h2F:7'h39],
                                 CH_PLUS, CH_DASH});
    endfunction

endpackage
`default_nettype wire

### rtl/utf7e_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf7e_front
// Front end: classifies each transaction, tracks base64 state and builds the
// complete list of output bytes as one job for the queue.
// ============================================================================
module utf7e_front
    import utf7e_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire logic        i_func,
    input  wire logic [30:0] i_code_point,
    output t_job             o_job
);

    logic       r_imap;
    logic [1:0] r_mode,  n_mode;
    logic [3:0] r_pend,  n_pend;

    logic        bmp, legal, direct, amp, is_shift, do_close;
    logic [6:0]  shift_ch, pend_dig, cp7;
    logic [19:0] cpm;
    logic [31:0] d32;
    logic [35:0] strm;
    logic [MAX_BYTES-1:0][6:0] dig;
    logic [2:0]  ndig;
    logic [1:0]  enc_mode;
    logic [3:0]  enc_pend;
    logic [2:0]  n;
    t_job        job;

    // Classification
    always_comb begin
        shift_ch = r_imap ? CH_AMP : CH_PLUS;
        cp7      = i_code_point[6:0];
        legal    = i_code_point < CP_LIMIT;
        bmp      = (i_code_point[30:16] == 15'd0);
        direct   = is_direct(i_code_point, r_imap);
        amp      = r_imap && (i_code_point == {24'd0, CH_AMP});
        is_shift = (i_code_point == {24'd0, shift_ch});
        do_close = amp || direct;
        pend_dig = b64_digit({r_pend, 2'b00}, r_imap);
    end

    // UTF-16 units and the base64 bit stream, held bits first
    always_comb begin
        cpm = 20'(i_code_point[20:0] - 21'h01_0000);
        d32 = bmp ? {i_code_point[15:0], 16'h0000}
                  : {6'b110110, cpm[19:10], 6'b110111, cpm[9:0]};
        case (r_mode)
            MODE_B64_2: strm = {r_pend[3:2], d32, 2'b00};
            MODE_B64_4: strm = {r_pend, d32};
            default:    strm = {d32, 4'b0000};
        endcase
        for (int k = 0; k < MAX_BYTES; k++) begin
            dig[k] = b64_digit(strm[35-6*k -: 6], r_imap);
        end
    end

    // Digit count and leftover bits per held-bit count and unit size
    always_comb begin
        if (bmp) begin
            case (r_mode)
                MODE_B64_4: begin
                    ndig = 3'd3; enc_mode = MODE_B64_2; enc_pend = strm[17:14];
                end
                MODE_B64_2: begin
                    ndig = 3'd3; enc_mode = MODE_B64_0; enc_pend = 4'd0;
                end
                default: begin
                    ndig = 3'd2; enc_mode = MODE_B64_4; enc_pend = strm[23:20];
                end
            endcase
        end else begin
            case (r_mode)
                MODE_B64_4: begin
                    ndig = 3'd6; enc_mode = MODE_B64_0; enc_pend = 4'd0;
                end
                MODE_B64_2: begin
                    ndig = 3'd5; enc_mode = MODE_B64_4; enc_pend = strm[5:2];
                end
                default: begin
                    ndig = 3'd5; enc_mode = MODE_B64_2; enc_pend = strm[5:2];
                end
            endcase
        end
    end

    // Byte list and next state
    always_comb begin
        job    = '0;
        n      = 3'd0;
        n_mode = r_mode;
        n_pend = r_pend;
        if (i_func == FUNC_FLUSH) begin
            if (r_mode != MODE_ASCII) begin
                if (r_mode == MODE_B64_2 || r_mode == MODE_B64_4) begin
                    job.bytes[n] = pend_dig;
                    n = n + 3'd1;
                end
                job.bytes[n] = CH_DASH;
                n = n + 3'd1;
            end
            n_mode = MODE_ASCII;
            n_pend = 4'd0;
        end else if (!legal) begin
            job.status = 1'b1;
        end else if (r_mode == MODE_ASCII && direct) begin
            job.bytes[0] = cp7;
            n = 3'd1;
        end else if (r_mode == MODE_ASCII && is_shift) begin
            job.bytes[0] = cp7;
            job.bytes[1] = CH_DASH;
            n = 3'd2;
        end else if (r_mode != MODE_ASCII && do_close) begin
            // leave base64 mode before the direct character
            if (r_mode == MODE_B64_2 || r_mode == MODE_B64_4) begin
                job.bytes[n] = pend_dig;
                n = n + 3'd1;
            end
            if (r_imap || explicit_close(i_code_point)) begin
                job.bytes[n] = CH_DASH;
                n = n + 3'd1;
            end
            job.bytes[n] = cp7;
            n = n + 3'd1;
            if (amp) begin
                job.bytes[n] = CH_DASH;
                n = n + 3'd1;
            end
            n_mode = MODE_ASCII;
            n_pend = 4'd0;
        end else begin
            // base64 encode, opening the mode first when in ASCII
            if (r_mode == MODE_ASCII) begin
                job.bytes[0] = shift_ch;
                n = 3'd1;
            end
            for (int k = 0; k < MAX_BYTES; k++) begin
                if (3'(k) < ndig) begin
                    job.bytes[n] = dig[k];
                    n = n + 3'd1;
                end
            end
            n_mode = enc_mode;
            n_pend = enc_pend;
        end
        job.vld = (n != 3'd0);
        job.cnt = job.vld ? n : 3'd1;
    end

    assign o_job = job;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imap <= 1'b0;
        end else if (i_cfg_we) begin
            r_imap <= i_cfg_wdata;
        end
    end

    // Encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ASCII;
            r_pend <= 4'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
        end
    end

endmodule
`default_nettype wire

### rtl/utf7e_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf7e_jobq
// Small job queue decoupling the front end from the byte serialiser.
// ============================================================================
module utf7e_jobq
    import utf7e_pkg::*;
#(
    parameter int unsigned DEPTH = JOBQ_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/utf7e_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf7e_back
// Back end: takes jobs from the queue and presents their bytes one result
// per cycle, while i_pop is held high, on the output queue interface.
// ============================================================================
module utf7e_back
    import utf7e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [6:0] o_out_byte,
    output logic      o_byte_valid,
    output logic      o_last,
    output logic      o_status
);

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;
    logic       last, take;

    // Current result
    assign last         = (r_idx == 3'(r_job.cnt - 3'd1));
    assign o_empty      = !r_busy;
    assign o_out_byte   = r_job.bytes[r_idx];
    assign o_byte_valid = r_job.vld;
    assign o_last       = last;
    assign o_status     = r_job.status;

    // Load the next job once the current one is drained
    assign take    = !r_busy || (i_pop && last);
    assign o_q_pop = take && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (take) begin
            r_busy <= !i_q_empty;
            r_idx  <= 3'd0;
        end else if (i_pop) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

endmodule
`default_nettype wire

### rtl/codepoint_to_utf7_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// codepoint_to_utf7_encoder
// UTF-7 encoder (standard or IMAP variant) from code points to ASCII bytes.
// ============================================================================
// Usage:
//  Input queue: drive i_func/i_code_point with push; a transaction is taken
//  on a clock edge with push high and full low. func 1 flushes base64 mode.
//  Output queue: while empty is low the oldest result is on o_out_byte,
//  o_byte_valid, o_last and o_status; pop takes it. Each transaction gives
//  one to six results, the final one marked by o_last; one that emits no
//  byte gives a single result with o_byte_valid low.
//  Path: a taken transaction is written to the job queue and then loaded
//  into the back end's job register, where its first result shows.
//  Throughput: one result per cycle while pop is held high, set by the single
//  output byte port; a transaction gives max(1, bytes) results, six at worst.
//  The front end takes one transaction per cycle while the job queue has room.
//  Stalls: holding pop low freezes the result; the job queue then fills and
//  full rises, without losing anything.
//  Reset: synchronous, active low; returns to ASCII mode, standard variant,
//  and empties all queues. i_cfg_we selects the variant; write it only
//  while no transaction is outstanding.
// ============================================================================
module codepoint_to_utf7_encoder
    import utf7e_pkg::*;
#(
    parameter int unsigned Q_DEPTH = JOBQ_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_func,
    input  wire logic [30:0] i_code_point,
    output logic             empty,
    input  wire logic        pop,
    output logic [6:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_last,
    output logic             o_status
);

    t_job fe_job, q_job;
    logic accept, q_empty, q_pop, q_full, out_pop;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign out_pop = pop && !empty;

    // Classification and state
    utf7e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_code_point (i_code_point),
        .o_job        (fe_job)
    );

    // Job queue
    utf7e_jobq #(
        .DEPTH (Q_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (fe_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    // Byte serialiser
    utf7e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_job      (q_job),
        .o_q_pop      (q_pop),
        .i_pop        (out_pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

### rtl/utf7e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf7e_checker
// Port-level checks on the encoder's result stream, bound to the top level.
// ============================================================================
module utf7e_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [6:0]  o_out_byte,
    input wire logic        o_byte_valid,
    input wire logic        o_last,
    input wire logic        o_status
);

    // Reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_last)
                           && $stable(o_byte_valid) && $stable(o_status))
        else $error("stalled result changed");

    // An empty result is the only result of its transaction and carries zero
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_last && (o_out_byte == 7'd0))
        else $error("malformed empty result");

    // A skipped code point emits no byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status |-> !o_byte_valid)
        else $error("byte emitted for illegal code point");

endmodule

bind codepoint_to_utf7_encoder utf7e_checker u_chk (.*);
`default_nettype wire
